// ===== hdl/b64e_pkg.sv =====
// Shared types, constants and the character mapping function of the base64 encoder.
package b64e_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
	} char_item_t;

	// One byte's worth of output: up to four characters, count kept minus one.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      cnt_m1;
		logic            last;
	} job_t;

	function automatic logic [7:0] sym(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26)
			return 8'h41 + v;
		else if (six < 6'd52)
			return 8'h61 + v - 8'd26;
		else if (six < 6'd62)
			return 8'h30 + v - 8'd52;
		else if (six == 6'd62)
			return 8'h2b;
		else
			return 8'h2f;
	endfunction

endpackage

// ===== hdl/b64e_front.sv =====
// Front end: takes input bytes, tracks group phase and builds character jobs.
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  b64e_pkg::byte_item_t byte_item,
	input  logic                q_full,
	output logic                push,
	output b64e_pkg::job_t      push_job
);
	import b64e_pkg::*;

	localparam logic [1:0] PH0 = 2'd0;
	localparam logic [1:0] PH1 = 2'd1;
	localparam logic [1:0] PH2 = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [3:0] left_q, left_d;
	logic [7:0] b;
	logic       fin;

	assign byte_ready = !q_full;
	assign push       = byte_valid && byte_ready;
	assign b          = byte_item.data_byte;
	assign fin        = byte_item.final_byte;

	always_comb begin
		push_job.chars  = {4{PAD_CHAR}};
		push_job.cnt_m1 = 2'd0;
		push_job.last   = 1'b0;
		phase_d         = PH0;
		left_d          = 4'd0;
		unique case (phase_q)
			PH1: begin
				push_job.chars[0] = sym({left_q[1:0], b[7:4]});
				if (fin) begin
					push_job.chars[1] = sym({b[3:0], 2'b00});
					push_job.cnt_m1   = 2'd2;
					push_job.last     = 1'b1;
				end else begin
					left_d  = b[3:0];
					phase_d = PH2;
				end
			end
			PH2: begin
				push_job.chars[0] = sym({left_q, b[7:6]});
				push_job.chars[1] = sym(b[5:0]);
				push_job.cnt_m1   = 2'd1;
				push_job.last     = fin;
			end
			default: begin
				push_job.chars[0] = sym(b[7:2]);
				if (fin) begin
					push_job.chars[1] = sym({b[1:0], 4'b0000});
					push_job.cnt_m1   = 2'd3;
					push_job.last     = 1'b1;
				end else begin
					left_d  = {2'b00, b[1:0]};
					phase_d = PH1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH0;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== hdl/b64e_queue.sv =====
// Small job queue between front end and character output.
module b64e_queue #(
	parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output b64e_pkg::job_t head_job
);
	import b64e_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = cnt_q == FULL_CNT;
	assign head_valid = cnt_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/b64e_back.sv =====
// Back end: walks the head job one character per cycle, while the output is not stalled, into the output register.
module b64e_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  b64e_pkg::job_t       head_job,
	output logic                 pop,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_item_t char_item
);
	import b64e_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	char_item_t out_item_q;
	logic       load;
	logic       at_end;

	assign load       = head_valid && (!out_valid_q || char_ready);
	assign at_end     = idx_q == head_job.cnt_m1;
	assign pop        = load && at_end;
	assign char_valid = out_valid_q;
	assign char_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.out_char  <= head_job.chars[idx_q];
			out_item_q.last_char <= head_job.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (char_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/base64_stream_encoder_core.sv =====
// Top level of the streaming base64 encoder.
// Takes one raw byte per item, with a flag on the last byte of a message, and
// gives standard-alphabet base64 characters, '=' padded to a four-character
// group, with last_char set on the final character of each message. A byte is
// accepted whenever the job queue (QUEUE_DEPTH entries) has room; each byte
// yields one to four characters and the output port gives one character per
// cycle while char_ready is high, so sustained throughput is set by that port.
// An accepted byte's job is written into the queue, and its characters then
// leave through the back end's output register.
// QUEUE_DEPTH must be 2 or more.
module base64_stream_encoder_core #(
	parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  b64e_pkg::byte_item_t byte_item,
	output logic                 char_valid,
	input  logic                 char_ready,
	output b64e_pkg::char_item_t char_item
);
	import b64e_pkg::*;

	logic push, pop, q_full, head_valid;
	job_t push_job, head_job;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule

// ===== sim/b64e_checker.sv =====
// Checker for the base64 encoder: predicts characters from accepted bytes and compares them.
module b64e_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_ready,
	input  b64e_pkg::byte_item_t byte_item,
	input  logic                 char_valid,
	input  logic                 char_ready,
	input  b64e_pkg::char_item_t char_item,
	output int                   fail_count,
	output int                   chars_pending
);
	import b64e_pkg::*;

	localparam logic [0:63][7:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	char_item_t expected_chars[$];
	char_item_t oldest_char;
	logic [1:0] group_phase;
	logic [3:0] carry_bits;

	function automatic logic [7:0] to_char(input logic [5:0] six);
		return ALPHABET[six];
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic last);
		char_item_t c;
		c.out_char  = ch;
		c.last_char = last;
		expected_chars.push_back(c);
	endtask

	task automatic encode_byte(input byte_item_t it);
		logic [7:0] b;
		logic       fin;
		b   = it.data_byte;
		fin = it.final_byte;
		case (group_phase)
		2'd1: begin
			push_char(to_char({carry_bits[1:0], b[7:4]}), 1'b0);
			if (fin) begin
				push_char(to_char({b[3:0], 2'b00}), 1'b0);
				push_char(PAD_CHAR, 1'b1);
				group_phase = 2'd0;
				carry_bits  = 4'd0;
			end else begin
				carry_bits  = b[3:0];
				group_phase = 2'd2;
			end
		end
		2'd2: begin
			push_char(to_char({carry_bits, b[7:6]}), 1'b0);
			push_char(to_char(b[5:0]), fin);
			group_phase = 2'd0;
			carry_bits  = 4'd0;
		end
		default: begin
			push_char(to_char(b[7:2]), 1'b0);
			if (fin) begin
				push_char(to_char({b[1:0], 4'b0000}), 1'b0);
				push_char(PAD_CHAR, 1'b0);
				push_char(PAD_CHAR, 1'b1);
				group_phase = 2'd0;
				carry_bits  = 4'd0;
			end else begin
				carry_bits  = {2'b00, b[1:0]};
				group_phase = 2'd1;
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_phase = 2'd0;
			carry_bits  = 4'd0;
			expected_chars.delete();
			fail_count = 0;
		end else begin
			if (byte_valid && byte_ready)
				encode_byte(byte_item);
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected char item, actual char %h last %b",
						$time, char_item.out_char, char_item.last_char);
				end else begin
					oldest_char = expected_chars.pop_front();
					if (char_item.out_char !== oldest_char.out_char) begin
						fail_count++;
						$display("%0t: out_char mismatch, expected %h actual %h",
							$time, oldest_char.out_char, char_item.out_char);
					end
					if (char_item.last_char !== oldest_char.last_char) begin
						fail_count++;
						$display("%0t: last_char mismatch, expected %b actual %b",
							$time, oldest_char.last_char, char_item.last_char);
					end
				end
			end
		end
		chars_pending = expected_chars.size();
	end

endmodule

// ===== sim/tb_base64_stream_encoder_core.sv =====
// Testbench top for the base64 encoder: clock, reset, byte and char traffic, verdict.
module tb_base64_stream_encoder_core;
	import b64e_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_item = '0;
	logic       char_valid;
	logic       char_ready = 1'b0;
	char_item_t char_item;

	int fail_count;
	int chars_pending;
	int cycle_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_pending = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	base64_stream_encoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item (char_item)
	);

	b64e_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_item    (char_item),
		.fail_count   (fail_count),
		.chars_pending(chars_pending)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				char_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			char_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// called and returns at a falling edge
	task automatic send_byte(input logic [7:0] data, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid           <= 1'b1;
		byte_item.data_byte  <= data;
		byte_item.final_byte <= fin;
		do
			@(posedge clk);
		while (!byte_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_message();
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 1);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)), i == len - 1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one-byte messages
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// two-byte message
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		// full groups: '+', '/', letters, digits
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hbe, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h4d, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6e, 1'b1);
		send_byte(8'hd3, 1'b0);
		send_byte(8'h4d, 1'b0);
		send_byte(8'h36, 1'b1);
		// four bytes: group then a one-byte tail
		send_byte(8'h69, 1'b0);
		send_byte(8'hb7, 1'b0);
		send_byte(8'h1d, 1'b0);
		send_byte(8'h79, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_pending   = 1'b1;
			end
			1: begin
				send_idle_pct  = 79;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 79;
			end
			default: begin
				send_idle_pct  = 10;
				recv_stall_pct = 10;
			end
			endcase
			while (bytes_sent < 20 + 21 * (ph + 1))
				send_message();
		end
		byte_valid <= 1'b0;

		while (chars_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
